>>> sv/srfm_pkg.sv
// ----------------------------------------------------------------------------
// srfm_pkg
// Shared types and constants for the streaming first-match replace block.
// ----------------------------------------------------------------------------
package srfm_pkg;

  localparam int MAX_PATTERN = 8;   // pattern and replacement bytes, at most
  localparam int MAX_HELD    = 7;   // bytes that can wait for a match decision
  localparam int WIN_BYTES   = MAX_HELD + 1;

  // configuration register indexes
  localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef logic [WIN_BYTES-1:0][7:0] srfm_window_t;

  typedef struct packed {
    logic [8*MAX_PATTERN-1:0] pattern_bytes;
    logic [3:0]               pattern_length;
    logic [8*MAX_PATTERN-1:0] replacement_bytes;
    logic [3:0]               replacement_length;
  } srfm_cfg_t;

  // everything one input word produces
  typedef struct packed {
    logic [3:0]                 n;           // result words, 0..8
    logic [MAX_PATTERN-1:0][7:0] bytes;
    logic                       carry;       // 0 only for the end-only marker
    logic                       done;        // stream ends on the last result
    logic [2:0]                 held_next;
    logic                       replaced_next;
  } srfm_result_t;

endpackage

>>> sv/srfm_match.sv
// ----------------------------------------------------------------------------
// srfm_match
// Single-pass match logic: longest held suffix that is a pattern prefix,
// and the result words for one input byte.
// ----------------------------------------------------------------------------
module srfm_match (
  input  srfm_pkg::srfm_cfg_t    cfg,
  input  srfm_pkg::srfm_window_t win,        // win[7] is the new byte
  input  logic [2:0]             held_count,
  input  logic                   replaced,
  input  logic                   eos,
  output srfm_pkg::srfm_result_t res
);

  logic [3:0] plen;
  logic [3:0] rlen;
  logic [3:0] len;
  logic [3:0] s_best;
  logic       bypass;
  logic       hit;
  logic [srfm_pkg::WIN_BYTES:1] ok;

  assign plen   = (cfg.pattern_length > 4'd8) ? 4'd8 : cfg.pattern_length;
  assign rlen   = (cfg.replacement_length > 4'd8) ? 4'd8 : cfg.replacement_length;
  assign len    = {1'b0, held_count} + 4'd1;
  assign bypass = replaced || (plen == 4'd0);

  // suffix of length s ends at win[7]; window is right-aligned
  always_comb begin
    logic eq;
    for (int s = 1; s <= srfm_pkg::WIN_BYTES; s++) begin
      eq = 1'b1;
      for (int i = 0; i < s; i++) begin
        if (win[srfm_pkg::WIN_BYTES - s + i] != cfg.pattern_bytes[8*i +: 8])
          eq = 1'b0;
      end
      ok[s] = eq && (4'(s) <= len) && (4'(s) <= plen);
    end
  end

  always_comb begin
    s_best = 4'd0;
    for (int s = 1; s <= srfm_pkg::WIN_BYTES; s++) begin
      if (ok[s])
        s_best = 4'(s);
    end
  end

  assign hit = (s_best == plen);

  always_comb begin
    logic [3:0] lead;
    lead              = len - s_best;
    res.carry         = 1'b1;
    res.done          = eos;
    res.held_next     = 3'd0;
    res.replaced_next = 1'b0;
    res.n             = 4'd0;
    res.bytes         = '0;
    if (bypass) begin
      res.n             = 4'd1;
      res.bytes[0]      = win[srfm_pkg::WIN_BYTES-1];
      res.replaced_next = replaced && !eos;
    end else if (hit) begin
      res.n             = rlen;
      res.bytes         = cfg.replacement_bytes;
      res.replaced_next = !eos;
      if (eos && rlen == 4'd0) begin
        res.n     = 4'd1;
        res.carry = 1'b0;
      end
    end else begin
      // held bytes plus the new one, oldest first; an end flushes them all
      for (int k = 0; k < srfm_pkg::MAX_PATTERN; k++)
        res.bytes[k] = win[3'(4'(k) - len)];
      res.n         = eos ? len : lead;
      res.held_next = eos ? 3'd0 : s_best[2:0];
    end
  end

endmodule

>>> sv/stream_replace_first_match_unit.sv
// ----------------------------------------------------------------------------
// stream_replace_first_match_unit
// Streaming find-and-replace of the first pattern match in a byte stream.
// ----------------------------------------------------------------------------
// A result word passes through the input register and then the result buffer;
// out_valid shows it, and the receiver takes it while out_stall is low.
// Throughput: one input word per cycle while each yields at most one result and
// out_stall stays low; a word with more results holds the buffer until all are taken.
// Reset clears configuration, held count, replaced flag and both valids.
module stream_replace_first_match_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        carries_data,
  output logic        stream_done
);

  srfm_pkg::srfm_cfg_t    cfg;
  srfm_pkg::srfm_window_t win;
  srfm_pkg::srfm_result_t res;

  logic [srfm_pkg::MAX_HELD-1:0][7:0] hist;   // hist[6] newest
  logic [2:0] held_count;
  logic       replaced;

  logic       iv;
  logic [7:0] idata;
  logic       ieos;

  logic                                res_valid;
  logic [3:0]                          res_n;
  logic [2:0]                          rd;
  logic [srfm_pkg::MAX_PATTERN-1:0][7:0] res_bytes;
  logic                                res_carry;
  logic                                res_done;

  logic last;
  logic out_take;
  logic buf_free;
  logic consume;
  logic pat_write;

  assign win = {idata, hist};

  srfm_match u_match (
    .cfg        (cfg),
    .win        (win),
    .held_count (held_count),
    .replaced   (replaced),
    .eos        (ieos),
    .res        (res)
  );

  assign last      = ({1'b0, rd} == (res_n - 4'd1));
  assign out_take  = res_valid && !out_stall;
  assign buf_free  = !res_valid || (out_take && last);
  assign consume   = iv && buf_free;
  assign in_stall  = iv && !consume;
  assign pat_write = cfg_we &&
                     (cfg_index inside {srfm_pkg::REG_PATTERN_BYTES,
                                        srfm_pkg::REG_PATTERN_LENGTH});

  assign out_valid    = res_valid;
  assign out_byte     = res_carry ? res_bytes[rd] : 8'd0;
  assign carries_data = res_carry;
  assign stream_done  = res_done && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg        <= '0;
      held_count <= 3'd0;
      replaced   <= 1'b0;
      iv         <= 1'b0;
      res_valid  <= 1'b0;
      rd         <= 3'd0;
      res_n      <= 4'd0;
      res_carry  <= 1'b0;
      res_done   <= 1'b0;
    end else begin
      if (consume && res.n != 4'd0) begin
        res_valid <= 1'b1;
        rd        <= 3'd0;
        res_n     <= res.n;
        res_carry <= res.carry;
        res_done  <= res.done;
      end else if (out_take) begin
        if (last)
          res_valid <= 1'b0;
        else
          rd <= rd + 3'd1;
      end
      // a pattern rewrite drops the held bytes
      if (pat_write)
        held_count <= 3'd0;
      else if (consume)
        held_count <= res.held_next;
      if (consume)
        replaced <= res.replaced_next;
      if (!iv || consume)
        iv <= in_valid;
      if (cfg_we) begin
        case (cfg_index)
          srfm_pkg::REG_PATTERN_BYTES:      cfg.pattern_bytes      <= cfg_data;
          srfm_pkg::REG_PATTERN_LENGTH:     cfg.pattern_length     <= cfg_data[3:0];
          srfm_pkg::REG_REPLACEMENT_BYTES:  cfg.replacement_bytes  <= cfg_data;
          srfm_pkg::REG_REPLACEMENT_LENGTH: cfg.replacement_length <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if ((!iv || consume) && in_valid) begin
      idata <= data_byte;
      ieos  <= end_of_stream;
    end
    if (consume) begin
      hist <= {idata, hist[srfm_pkg::MAX_HELD-1:1]};
      if (res.n != 4'd0)
        res_bytes <= res.bytes;
    end
  end

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ({1'b0, rd} < res_n))
    else $error("result read index past word count");

  a_replaced_no_hold: assert property (@(posedge clk) disable iff (rst)
    replaced |-> (held_count == 3'd0))
    else $error("bytes held after replacement");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (consume && ieos && !cfg_we) |=> (held_count == 3'd0 && !replaced))
    else $error("stream state not cleared at end of stream");

  a_marker_alone: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_carry) |-> (res_n == 4'd1 && res_done))
    else $error("end-only marker not a single final word");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for stream_replace_first_match_unit: a stimulus table and then
// random streams over random pattern and replacement settings. Every output
// word is checked against an in-bench find-and-replace predictor or a typed word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_WORDS = 370;
  localparam int DRAIN_CYCLES = 8;      // margin after the last expected word
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_PRINTED  = 30;

  typedef struct packed {
    logic [7:0] value;
    logic       has_data;
    logic       done;
  } out_word_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] idx;
    logic [63:0] val;
    logic [7:0] b;
    logic       eos;
    bit         typed;
    out_word_t  want;
  } dir_row_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        end_of_stream;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        carries_data;
  logic        stream_done;

  stream_replace_first_match_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .carries_data  (carries_data),
    .stream_done   (stream_done)
  );

  // predictor copy of configuration and per-stream state
  logic [63:0] cfg_pattern = '0;
  logic [3:0]  cfg_pat_len = '0;
  logic [63:0] cfg_repl    = '0;
  logic [3:0]  cfg_repl_len = '0;
  logic [7:0]  held [0:srfm_pkg::MAX_HELD-1];
  int          held_cnt = 0;
  bit          seen_replace = 0;

  out_word_t   due_words[$];
  out_word_t   step_words[$];
  dir_row_t    dir_rows[$];

  int cycles = 0;
  int err_count = 0;
  int words_sent = 0;
  int burst_left = 0;
  int hold_asks = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL stream_replace_first_match_unit");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic void push_word(inout int n, input logic [7:0] b, input logic d);
    out_word_t w;
    if (n < srfm_pkg::MAX_PATTERN) begin
      w.value = d ? b : 8'h00;
      w.has_data = d;
      w.done = 1'b0;
      step_words.push_back(w);
      n++;
    end
  endfunction

  // one input word through the first-match replacer; results go to step_words
  function automatic void find_replace_step(input logic [7:0] b, input logic eos);
    logic [7:0] cand [0:srfm_pkg::MAX_PATTERN];
    int plen, rlen, len, s, lead, n, i;
    bit found;
    step_words.delete();
    n = 0;
    plen = (cfg_pat_len > srfm_pkg::MAX_PATTERN) ? srfm_pkg::MAX_PATTERN : int'(cfg_pat_len);
    if (seen_replace || plen == 0) begin
      push_word(n, b, 1'b1);
    end else begin
      len = held_cnt;
      for (i = 0; i < len; i++) cand[i] = held[i];
      cand[len] = b;
      len++;
      // longest tail of the window that is still a pattern prefix
      s = (len < plen) ? len : plen;
      found = 0;
      while (!found && s > 0) begin
        found = 1;
        for (i = 0; i < s; i++)
          if (cand[len-s+i] != cfg_pattern[8*i +: 8]) found = 0;
        if (!found) s--;
      end
      lead = len - s;
      for (i = 0; i < lead; i++) push_word(n, cand[i], 1'b1);
      if (s == plen) begin
        rlen = (cfg_repl_len > 8) ? 8 : int'(cfg_repl_len);
        for (i = 0; i < rlen; i++) push_word(n, cfg_repl[8*i +: 8], 1'b1);
        held_cnt = 0;
        seen_replace = 1;
      end else begin
        for (i = 0; i < s; i++) held[i] = cand[lead+i];
        held_cnt = s;
      end
    end
    if (eos) begin
      for (i = 0; i < held_cnt; i++) push_word(n, held[i], 1'b1);
      held_cnt = 0;
      seen_replace = 0;
      if (n == 0) push_word(n, 8'h00, 1'b0);
      step_words[step_words.size()-1].done = 1'b1;
    end
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      srfm_pkg::REG_PATTERN_BYTES: begin
        cfg_pattern = val;
        held_cnt = 0;
      end
      srfm_pkg::REG_PATTERN_LENGTH: begin
        cfg_pat_len = val[3:0];
        held_cnt = 0;
      end
      srfm_pkg::REG_REPLACEMENT_BYTES: cfg_repl = val;
      default: cfg_repl_len = val[3:0];
    endcase
  endtask

  task automatic send_word(input logic [7:0] b, input logic eos, input bit typed,
                           input out_word_t want);
    if (burst_left == 0) begin
      in_valid = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid = 1;
    data_byte = b;
    end_of_stream = eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    find_replace_step(b, eos);
    if (typed) due_words.push_back(want);
    else foreach (step_words[i]) due_words.push_back(step_words[i]);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [63:0] len_word(input int len);
    return {32'($urandom), 28'($urandom), 4'(len)};
  endfunction

  task automatic random_config(input bit all_regs);
    logic [7:0] abc [0:2];
    logic [63:0] pat;
    int i, pick, plen, rlen;
    for (i = 0; i < 3; i++) abc[i] = 8'($urandom_range(0, 255));
    // small alphabet so the pattern overlaps itself
    for (i = 0; i < 8; i++) pat[8*i +: 8] = abc[$urandom_range(0, 2)];
    pick = $urandom_range(0, 9);
    plen = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 15) :
           (pick == 2) ? 8 : $urandom_range(1, 4);
    pick = $urandom_range(0, 9);
    rlen = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    if (all_regs || $urandom_range(0, 3) != 0)
      write_reg(srfm_pkg::REG_PATTERN_BYTES, pat);
    if (all_regs || $urandom_range(0, 3) != 0)
      write_reg(srfm_pkg::REG_PATTERN_LENGTH, len_word(plen));
    if (all_regs || $urandom_range(0, 1) != 0)
      write_reg(srfm_pkg::REG_REPLACEMENT_BYTES, {32'($urandom), 32'($urandom)});
    if (all_regs || $urandom_range(0, 1) != 0)
      write_reg(srfm_pkg::REG_REPLACEMENT_LENGTH, len_word(rlen));
  endtask

  task automatic random_stream(input int n_items);
    out_word_t none;
    int k, i, cut, pick, plen;
    logic eos;
    none = '0;
    plen = (cfg_pat_len > srfm_pkg::MAX_PATTERN) ? srfm_pkg::MAX_PATTERN : int'(cfg_pat_len);
    k = 0;
    while (k < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 4 && plen > 0) begin
        // whole pattern, or now and then a broken prefix
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, plen) : plen;
        for (i = 0; i < cut; i++) begin
          eos = (i == cut - 1) && ($urandom_range(0, 7) == 0);
          send_word(cfg_pattern[8*i +: 8], eos, 0, none);
          k++;
        end
      end else begin
        eos = ($urandom_range(0, 9) == 0);
        if (pick < 8)
          send_word(cfg_pattern[8*$urandom_range(0, (plen > 0) ? plen - 1 : 7) +: 8],
                    eos, 0, none);
        else
          send_word(8'($urandom_range(0, 255)), eos, 0, none);
        k++;
      end
    end
    // sometimes leave the stream open across the next register writes
    if ($urandom_range(0, 3) != 0) send_word(8'($urandom_range(0, 255)), 1, 0, none);
  endtask

  task automatic row_word(input logic [7:0] b, input logic eos);
    dir_row_t r;
    r.kind = ROW_WORD; r.idx = '0; r.val = '0;
    r.b = b; r.eos = eos; r.typed = 0; r.want = '0;
    dir_rows.push_back(r);
  endtask

  task automatic row_typed(input logic [7:0] b, input logic eos, input logic [7:0] v,
                           input logic d, input logic done);
    dir_row_t r;
    r.kind = ROW_WORD; r.idx = '0; r.val = '0;
    r.b = b; r.eos = eos; r.typed = 1;
    r.want.value = v; r.want.has_data = d; r.want.done = done;
    dir_rows.push_back(r);
  endtask

  task automatic row_cfg(input logic [1:0] idx, input logic [63:0] val);
    dir_row_t r;
    r.kind = ROW_CFG; r.idx = idx; r.val = val;
    r.b = '0; r.eos = 0; r.typed = 0; r.want = '0;
    dir_rows.push_back(r);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h data=%0b done=%0b",
                                  out_byte, carries_data, stream_done));
      end else begin
        want = due_words.pop_front();
        if (out_byte !== want.value)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.value));
        if (carries_data !== want.has_data)
          report_mismatch($sformatf("carries_data %0b, want %0b", carries_data, want.has_data));
        if (stream_done !== want.done)
          report_mismatch($sformatf("stream_done %0b, want %0b", stream_done, want.done));
      end
    end
  end

  // receiver: stall pattern of its own, plus long hold-offs on request
  initial begin
    rx_mode_t mode;
    int mode_left, hold_left, hold_seen;
    mode = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          RX_FREE:   out_stall = 0;
          RX_LIGHT:  out_stall = ($urandom_range(0, 9) < 3);
          RX_HEAVY:  out_stall = ($urandom_range(0, 9) < 7);
          default:   out_stall = ~out_stall;
        endcase
      end
    end
  end

  initial begin
    int phase;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    data_byte = '0;
    end_of_stream = 0;
    repeat (8) @(negedge clk);
    rst = 0;

    // pass-through straight after reset
    row_typed(8'h00, 0, 8'h00, 1, 0);
    row_typed(8'hFF, 1, 8'hFF, 1, 1);
    // "ab" -> "XYZ", with a fallback on "aab"
    row_cfg(srfm_pkg::REG_PATTERN_BYTES, 64'h6261);
    row_cfg(srfm_pkg::REG_PATTERN_LENGTH, 64'd2);
    row_cfg(srfm_pkg::REG_REPLACEMENT_BYTES, 64'h5A5958);
    row_cfg(srfm_pkg::REG_REPLACEMENT_LENGTH, 64'd3);
    row_word(8'h78, 0);
    row_word(8'h61, 0);
    row_word(8'h61, 0);
    row_word(8'h62, 0);
    row_word(8'h61, 0);
    row_typed(8'h62, 1, 8'h62, 1, 1);
    // deletion leaves only the end marker; a held prefix is flushed at end
    row_cfg(srfm_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
    row_word(8'h61, 0);
    row_typed(8'h62, 1, 8'h00, 0, 1);
    row_typed(8'h61, 1, 8'h61, 1, 1);
    // lengths above 8 act as 8: eight pattern bytes give eight replacement words
    row_cfg(srfm_pkg::REG_PATTERN_BYTES, '1);
    row_cfg(srfm_pkg::REG_PATTERN_LENGTH, 64'd15);
    row_cfg(srfm_pkg::REG_REPLACEMENT_BYTES, 64'h0123456789ABCDEF);
    row_cfg(srfm_pkg::REG_REPLACEMENT_LENGTH, 64'd15);
    repeat (8) row_word(8'hFF, 0);
    row_typed(8'h00, 1, 8'h00, 1, 1);
    // pattern rewrite while bytes are held drops them
    row_cfg(srfm_pkg::REG_PATTERN_BYTES, 64'd0);
    row_cfg(srfm_pkg::REG_PATTERN_LENGTH, 64'd3);
    row_word(8'h00, 0);
    row_word(8'h00, 0);
    row_cfg(srfm_pkg::REG_PATTERN_BYTES, 64'd0);
    row_typed(8'h00, 1, 8'h00, 1, 1);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    words_sent = 0;
    phase = 0;
    while (words_sent < RANDOM_WORDS) begin
      wait_idle();
      random_config(phase == 0);
      if (phase == 2 || phase == 6) begin
        // receiver holds off while the sender keeps pushing
        hold_asks++;
        burst_left = 200;
      end
      random_stream($urandom_range(20, 45));
      phase++;
    end

    wait_idle();
    if (err_count == 0) begin
      $display("PASS stream_replace_first_match_unit");
    end else begin
      $display("FAIL stream_replace_first_match_unit");
    end
    $finish;
  end

endmodule
